/* hw/rtl/pctd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg: shared types and constants of the percent decoder
// Item structs, escape phase encoding, hex digit helper and queue sizing.
// ----------------------------------------------------------------------------
package pctd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Most result items one input item can cause
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned RES_CNT_W = 2;

  // Result queue sizing
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = 3;
  localparam int unsigned CNT_W      = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Results of one decoded item, in order, slot 0 first
  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    out_item_t [MAX_RES-1:0] items;
  } dec_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.ok  = 1'b1;
      h.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return h;
  endfunction

endpackage

/* hw/rtl/pctd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_decode: escape decode for one item
// Works out the result items and the next escape state from the current
// state and one input byte; purely combinational.
// ----------------------------------------------------------------------------
module pctd_decode (
  input  pctd_pkg::in_item_t  item,
  input  logic [1:0]          phase,
  input  logic [7:0]          held,
  output pctd_pkg::dec_res_t  res,
  output pctd_pkg::phase_t    phase_nxt,
  output logic [7:0]          held_nxt
);

  pctd_pkg::hex_t h_in;
  pctd_pkg::hex_t h_held;
  logic           is_pct;

  assign h_in   = pctd_pkg::hex_digit(item.in_byte);
  assign h_held = pctd_pkg::hex_digit(held);
  assign is_pct = (item.in_byte == pctd_pkg::PCT_CHAR);

  // Decide results and next state
  always_comb begin
    res       = '0;
    phase_nxt = pctd_pkg::PH_IDLE;
    held_nxt  = held;
    case (phase)
      pctd_pkg::PH_PCT: begin
        if (item.in_last) begin
          // escape cut off: flush the '%' then the final byte
          res.items[0] = '{out_byte: pctd_pkg::PCT_CHAR, out_last: 1'b0};
          res.items[1] = '{out_byte: item.in_byte, out_last: 1'b1};
          res.count    = 2'd2;
        end else if (h_in.ok) begin
          held_nxt  = item.in_byte;
          phase_nxt = pctd_pkg::PH_DIGIT;
        end else begin
          // malformed: emit '%', then treat the byte afresh
          res.items[0] = '{out_byte: pctd_pkg::PCT_CHAR, out_last: 1'b0};
          if (is_pct) begin
            phase_nxt = pctd_pkg::PH_PCT;
            res.count = 2'd1;
          end else begin
            res.items[1] = '{out_byte: item.in_byte, out_last: 1'b0};
            res.count    = 2'd2;
          end
        end
      end
      pctd_pkg::PH_DIGIT: begin
        if (h_held.ok && h_in.ok && (|{h_held.val, h_in.val})) begin
          res.items[0] = '{out_byte: {h_held.val, h_in.val}, out_last: item.in_last};
          res.count    = 2'd1;
        end else begin
          // malformed or %00: emit '%' and the held digit literally
          res.items[0] = '{out_byte: pctd_pkg::PCT_CHAR, out_last: 1'b0};
          res.items[1] = '{out_byte: held, out_last: 1'b0};
          if (is_pct && !item.in_last) begin
            phase_nxt = pctd_pkg::PH_PCT;
            res.count = 2'd2;
          end else begin
            res.items[2] = '{out_byte: item.in_byte, out_last: item.in_last};
            res.count    = 2'd3;
          end
        end
      end
      default: begin
        // idle, and the unused phase code
        if (is_pct && !item.in_last) begin
          phase_nxt = pctd_pkg::PH_PCT;
        end else begin
          res.items[0] = '{out_byte: item.in_byte, out_last: item.in_last};
          res.count    = 2'd1;
        end
      end
    endcase
  end

endmodule

/* hw/rtl/pctd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_fifo: result queue
// Takes up to three items per cycle in order, pops one per unstalled cycle.
// ----------------------------------------------------------------------------
module pctd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  pctd_pkg::dec_res_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output pctd_pkg::out_item_t out_item
);

  pctd_pkg::out_item_t             mem_r [pctd_pkg::FIFO_DEPTH];
  logic [pctd_pkg::PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pctd_pkg::PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pctd_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                            pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // Room for a worst-case burst from one item
  assign room      = (count_r <= pctd_pkg::CNT_W'(pctd_pkg::FIFO_DEPTH - pctd_pkg::MAX_RES));

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + pctd_pkg::PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + pctd_pkg::PTR_W'(pop);
    count_nxt  = count_r + pctd_pkg::CNT_W'(push.count) - pctd_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the new items at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < pctd_pkg::MAX_RES; i++) begin
      if (pctd_pkg::RES_CNT_W'(i) < push.count) begin
        mem_r[wr_ptr_r + pctd_pkg::PTR_W'(i)] <= push.items[i];
      end
    end
  end

endmodule

/* hw/rtl/percent_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decoder_top: streaming URI percent-escape decoder
// Decodes '%XY' escapes in a byte stream; each string ends with a last mark.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_item carries one raw byte per item with
//   its end-of-string mark. Output channel out_valid/out_stall/out_item gives
//   the decoded bytes; the last decoded byte of a string carries out_last.
//   Each input item is decoded in the cycle it is accepted and its zero to
//   three results land in an eight-entry result queue; the first result is
//   offered after those ahead of it. One input item is taken every cycle
//   while the queue has room for three more results, so the sustained rate
//   is one item per cycle, bounded by the single output port draining one
//   result per cycle unless stalled. in_stall rises when the queue holds more
//   than five results, which happens only when the receiver stalls out_stall.
//   Reset empties the queue and clears any pending escape; the '%' and first
//   digit of a pending escape are held in registers between items.
// ----------------------------------------------------------------------------
module percent_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pctd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pctd_pkg::out_item_t out_item
);

  pctd_pkg::phase_t   phase_r, phase_nxt, dec_phase;
  logic [7:0]         held_r, held_nxt, dec_held;
  pctd_pkg::dec_res_t dec_res;
  pctd_pkg::dec_res_t push;
  logic               room;
  logic               accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  pctd_decode u_decode (
    .item      (in_item),
    .phase     (phase_r),
    .held      (held_r),
    .res       (dec_res),
    .phase_nxt (dec_phase),
    .held_nxt  (dec_held)
  );

  // Hold escape state unless an item is taken
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    push      = '0;
    if (accept) begin
      phase_nxt = dec_phase;
      held_nxt  = dec_held;
      push      = dec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pctd_pkg::PH_IDLE;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  pctd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* tb/sv/pctd_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_decode_checker: scoreboard for the percent decoder
// Watches both channels, predicts the decoded bytes of every accepted raw
// byte with its own escape tracker and compares each result item in order.
// ----------------------------------------------------------------------------
module pctd_decode_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pctd_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pctd_pkg::out_item_t out_item,
  output int unsigned         mismatches,
  output int unsigned         pending
);

  localparam int unsigned REPORT_MAX = 10;

  pctd_pkg::out_item_t decoded_q[$];
  pctd_pkg::phase_t    esc_phase = pctd_pkg::PH_IDLE;
  logic [7:0]          first_digit = '0;
  int unsigned         err_cnt = 0;

  // Value of a hex digit of either case, -1 for any other byte
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  task automatic queue_decoded(input logic [7:0] b, input logic last);
    pctd_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = last;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  // Handle a byte with no escape pending; a '%' that ends the string is literal
  task automatic take_plain_byte(input logic [7:0] b, input logic last);
    if (b == pctd_pkg::PCT_CHAR && !last) begin
      esc_phase = pctd_pkg::PH_PCT;
    end else begin
      esc_phase = pctd_pkg::PH_IDLE;
      queue_decoded(b, last);
    end
  endtask

  // Advance the escape tracker by one raw byte and queue what it yields
  task automatic decode_raw_byte(input logic [7:0] b, input logic last);
    int hi;
    int lo;
    hi = nibble_of(first_digit);
    lo = nibble_of(b);
    case (esc_phase)
      pctd_pkg::PH_PCT: begin
        if (last) begin
          // escape cut off right after the '%'
          queue_decoded(pctd_pkg::PCT_CHAR, 1'b0);
          queue_decoded(b, 1'b1);
          esc_phase = pctd_pkg::PH_IDLE;
        end else if (lo >= 0) begin
          first_digit = b;
          esc_phase = pctd_pkg::PH_DIGIT;
        end else begin
          queue_decoded(pctd_pkg::PCT_CHAR, 1'b0);
          take_plain_byte(b, 1'b0);
        end
      end
      pctd_pkg::PH_DIGIT: begin
        // %00 stays literal, as does a bad second digit
        if (hi >= 0 && lo >= 0 && (hi + lo) > 0) begin
          queue_decoded({4'(hi), 4'(lo)}, last);
          esc_phase = pctd_pkg::PH_IDLE;
        end else begin
          queue_decoded(pctd_pkg::PCT_CHAR, 1'b0);
          queue_decoded(first_digit, 1'b0);
          take_plain_byte(b, last);
        end
      end
      default: take_plain_byte(b, last);
    endcase
  endtask

  // Check results before predicting: a result never stems from this edge's item
  always @(posedge clk) begin
    pctd_pkg::out_item_t want;
    if (!rst_n) begin
      esc_phase = pctd_pkg::PH_IDLE;
      first_digit = '0;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("%0t: unexpected result item byte %02h last %0b",
                     $realtime, out_item.out_byte, out_item.out_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_item.out_byte !== want.out_byte || out_item.out_last !== want.out_last) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $display({"%0t: result mismatch: expected byte %02h last %0b,",
                        " got byte %02h last %0b"},
                       $realtime, want.out_byte, want.out_last,
                       out_item.out_byte, out_item.out_last);
          end
        end
      end
      if (in_valid && !in_stall)
        decode_raw_byte(in_item.in_byte, in_item.in_last);
    end
    mismatches <= err_cnt;
    pending <= decoded_q.size();
  end

endmodule

/* tb/sv/percent_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decoder_top_tb: regression bench for the percent decoder
// Feeds directed escape corner cases and random strings in bursts against a
// stalling receiver; the checker beside the block scores every result item.
// ----------------------------------------------------------------------------
module percent_decoder_top_tb;

  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pctd_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pctd_pkg::out_item_t out_item;
  logic                in_took = 1'b0;
  int unsigned         mismatches;
  int unsigned         pending;
  int unsigned         idle_cycles = 0;

  pctd_pkg::in_item_t  raw_q[$];
  stall_mode_t         stall_mode = STALL_NONE;
  int unsigned         stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  percent_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  pctd_decode_checker decode_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Note each accepted input item for the driver
  always @(posedge clk)
    in_took <= rst_n && in_valid && !in_stall;

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("percent_decoder_top regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure: switch between randomly chosen stall styles
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 60);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
      default:     out_stall <= stall_left[1];
    endcase
  end

  task automatic push_raw(input logic [7:0] b, input logic last);
    pctd_pkg::in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    raw_q.insert(raw_q.size(), it);
  endtask

  // One string, last mark on its final byte
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_raw(s[i], i == s.len() - 1);
  endtask

  // Random hex digit, random letter case
  function automatic logic [7:0] pick_hex_digit();
    int unsigned n;
    n = $urandom_range(0, 15);
    if (n < 10) return 8'(8'h30 + n);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 10);
  endfunction

  // Random strings: mostly well-formed escapes and plain bytes, some strays
  task automatic build_random_strings();
    logic [7:0]  chunk[$];
    int unsigned len;
    int unsigned pick;
    while (raw_q.size() < RANDOM_ITEMS + 26) begin
      chunk.delete();
      len = $urandom_range(1, 12);
      while (chunk.size() < len) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
        end else if (pick < 70) begin
          chunk.insert(chunk.size(), pctd_pkg::PCT_CHAR);
          if ($urandom_range(0, 9) == 0) begin
            chunk.insert(chunk.size(), 8'h30);
            chunk.insert(chunk.size(), 8'h30);
          end else begin
            chunk.insert(chunk.size(), pick_hex_digit());
            chunk.insert(chunk.size(), pick_hex_digit());
          end
        end else if (pick < 82) begin
          chunk.insert(chunk.size(), pctd_pkg::PCT_CHAR);
        end else begin
          chunk.insert(chunk.size(), pick_hex_digit());
        end
      end
      foreach (chunk[i])
        push_raw(chunk[i], i == chunk.size() - 1);
    end
  endtask

  initial begin
    int unsigned sent_idx;
    int unsigned burst_left;
    int unsigned gap_left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;

    // Directed corner cases
    push_raw(8'h00, 1'b1);
    add_text("%41");
    add_text("%aF");
    add_text("%00");
    add_text("%%41");
    add_text("%Gz");
    add_text("%4Z");
    push_raw(pctd_pkg::PCT_CHAR, 1'b0);
    push_raw(8'hFF, 1'b1);
    add_text("%4%");
    add_text("%");
    build_random_strings();

    // Hold reset, then release on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drive items in bursts with gaps; hold a stalled item unchanged
    sent_idx = 0;
    burst_left = 0;
    gap_left = 0;
    while (sent_idx < raw_q.size()) begin
      @(negedge clk);
      if (in_valid && in_took)
        sent_idx++;
      if (sent_idx >= raw_q.size()) begin
        in_valid <= 1'b0;
      end else if (!in_valid || in_took) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_item <= raw_q[sent_idx];
          burst_left--;
        end
      end
    end

    // Drain outstanding results, then give the verdict; a leftover result fails
    while (pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && !out_valid)
      $display("percent_decoder_top regression: pass");
    else
      $display("percent_decoder_top regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pctd_pkg.sv
hw/rtl/pctd_decode.sv
hw/rtl/pctd_fifo.sv
hw/rtl/percent_decoder_top.sv
tb/sv/pctd_decode_checker.sv
tb/sv/percent_decoder_top_tb.sv
